>>> hdl/mpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority queue package
// Types, codes and field widths shared by the queue cells, the top level and
// the checker.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned PriW   = 8;
  localparam int unsigned CountW = 5;
  localparam int unsigned StatW  = 2;

  // Input tdata: process_id, priority_req. Output tdata: status, removed_id,
  // removed_priority, entry_count, padded to whole bytes.
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One stored entry as a cell presents it to its neighbours.
  typedef struct packed {
    logic            valid;
    logic [IdW-1:0]  id;
    logic [PriW-1:0] pri;
  } entry_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [IdW-1:0]  id;
    logic [PriW-1:0] pri;
  } cmd_t;

endpackage : mpq_pkg
`default_nettype wire

>>> hdl/mpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority queue cell
// Holds one entry of the sorted chain. On an insert it keeps its entry, takes
// the new one, or takes its upper neighbour's entry; on a remove it takes its
// lower neighbour's entry.
// ----------------------------------------------------------------------------
module mpq_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mpq_pkg::cmd_t   cmd_i,
  input  wire mpq_pkg::entry_t prev_i,
  input  wire logic            prev_before_i,
  input  wire mpq_pkg::entry_t next_i,
  output mpq_pkg::entry_t      entry_o,
  output logic                 before_o
);
  import mpq_pkg::*;

  logic            valid_q, valid_d;
  logic [IdW-1:0]  id_q, id_d;
  logic [PriW-1:0] pri_q, pri_d;

  // The new entry belongs ahead of this one. Strict compare keeps equal
  // priorities in arrival order.
  assign before_o = !valid_q || (cmd_i.pri > pri_q);

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    pri_d   = pri_q;
    if (cmd_i.ins && before_o) begin
      if (prev_before_i) begin
        valid_d = prev_i.valid;
        id_d    = prev_i.id;
        pri_d   = prev_i.pri;
      end else begin
        valid_d = 1'b1;
        id_d    = cmd_i.id;
        pri_d   = cmd_i.pri;
      end
    end else if (cmd_i.rem) begin
      valid_d = next_i.valid;
      id_d    = next_i.id;
      pri_d   = next_i.pri;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    pri_q <= pri_d;
  end

  assign entry_o = '{valid: valid_q, id: id_q, pri: pri_q};

endmodule : mpq_cell
`default_nettype wire

>>> hdl/max_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Max priority queue
// Bounded queue of process entries, served largest priority first.
// ----------------------------------------------------------------------------
// Entries live in a chain of CAPACITY cells kept sorted with the entry to be
// served next in the first cell; equal priorities stay in arrival order. Every
// transaction updates all cells at once: an insert moves each lower-ranked
// entry one cell down, a remove moves every entry one cell up. The result is
// held in an output register and appears in the cycle after acceptance; a new
// transaction is taken in every cycle in which that register is empty or being
// emptied, so the sustained rate is one item per cycle.
// ----------------------------------------------------------------------------
module max_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] process_id, [23:16] priority_req
  input  wire logic [mpq_pkg::InDataW-1:0]    s_axis_tdata,
  // [0] action
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [1:0] status, [17:2] removed_id, [25:18] removed_priority,
  // [30:26] entry_count, [31] zero
  output logic [mpq_pkg::OutDataW-1:0]        m_axis_tdata
);
  import mpq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic            accept;
  logic            full, empty;
  cmd_t            cmd;
  entry_t          cell_entry [CAPACITY];
  logic            cell_before [CAPACITY];
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  status_e         status;
  logic [31:0]     count_ext;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CntW'(CAPACITY));
  assign empty         = !cell_entry[0].valid;

  always_comb begin
    cmd.ins = accept && (s_axis_tuser == ACT_INSERT) && !full;
    cmd.rem = accept && (s_axis_tuser == ACT_REMOVE) && !empty;
    cmd.id  = s_axis_tdata[IdW-1:0];
    cmd.pri = s_axis_tdata[IdW+PriW-1:IdW];
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_b;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_b = 1'b0;
    end else begin : g_body
      assign prev_e = cell_entry[i-1];
      assign prev_b = cell_before[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_link
      assign next_e = cell_entry[i+1];
    end
    mpq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .prev_i        (prev_e),
      .prev_before_i (prev_b),
      .next_i        (next_e),
      .entry_o       (cell_entry[i]),
      .before_o      (cell_before[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    status = ST_DONE;
    if (s_axis_tuser == ACT_INSERT) begin
      if (full) begin
        status = ST_FULL;
      end
    end else if (empty) begin
      status = ST_EMPTY;
    end
    count_ext  = 32'(count_d);
    out_data_d = '0;
    out_data_d[StatW-1:0] = status;
    if (cmd.rem) begin
      out_data_d[StatW+IdW-1:StatW]           = cell_entry[0].id;
      out_data_d[StatW+IdW+PriW-1:StatW+IdW]  = cell_entry[0].pri;
    end
    out_data_d[StatW+IdW+PriW+CountW-1:StatW+IdW+PriW] = count_ext[CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule : max_priority_queue
`default_nettype wire

>>> hdl/mpq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority queue checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module mpq_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [mpq_pkg::OutDataW-1:0] m_axis_tdata
);
  import mpq_pkg::*;

  logic [StatW-1:0]  st;
  logic [IdW-1:0]    rid;
  logic [PriW-1:0]   rpri;
  logic [CountW-1:0] cnt;

  assign st   = m_axis_tdata[StatW-1:0];
  assign rid  = m_axis_tdata[StatW+IdW-1:StatW];
  assign rpri = m_axis_tdata[StatW+IdW+PriW-1:StatW+IdW];
  assign cnt  = m_axis_tdata[StatW+IdW+PriW+CountW-1:StatW+IdW+PriW];

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A transaction accepted while the result side is free yields a result.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted transaction produced no result");

  // Refused transactions carry no entry.
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_FULL || st == ST_EMPTY) |-> rid == '0 && rpri == '0)
    else $error("refused transaction carries an entry");

  // An empty refusal reports an empty queue.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == ST_EMPTY |-> cnt == '0)
    else $error("empty status with non-zero count");

  // A full refusal reports a full queue.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == ST_FULL |-> cnt == CountW'(CAPACITY))
    else $error("full status with wrong count");

endmodule : mpq_checker

bind max_priority_queue mpq_checker #(
  .CAPACITY (CAPACITY)
) u_mpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> tb/max_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max priority queue testbench
// Drives inserts and removes through the input stream and keeps a behavioural
// copy of the queue. Every response is checked field by field against the
// copy. Both stream sides stall at random in varying proportions.
// ----------------------------------------------------------------------------
module max_priority_queue_tb;

  import mpq_pkg::*;

  localparam int unsigned Capacity  = 16;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned PhaseLen  = 500;

  // Output tdata from the most significant bit down.
  typedef struct packed {
    logic              pad;
    logic [CountW-1:0] count;
    logic [PriW-1:0]   pri;
    logic [IdW-1:0]    id;
    status_e           status;
  } response_t;

  class queue_scoreboard;
    // Stored entries in order of arrival.
    logic [IdW-1:0]  model_ids[$];
    logic [PriW-1:0] model_pris[$];
    response_t       expected_responses[$];
    int unsigned     mismatches = 0;

    function void note_request(action_e act, logic [IdW-1:0] pid, logic [PriW-1:0] pri);
      response_t   rsp;
      int unsigned best;
      rsp = '0;
      rsp.status = ST_DONE;
      if (act == ACT_INSERT) begin
        if (model_ids.size() >= Capacity) begin
          rsp.status = ST_FULL;
        end else begin
          model_ids.push_back(pid);
          model_pris.push_back(pri);
        end
      end else if (model_ids.size() == 0) begin
        rsp.status = ST_EMPTY;
      end else begin
        // A strict comparison keeps the earliest of equal priorities.
        best = 0;
        for (int unsigned i = 1; i < model_ids.size(); i++) begin
          if (model_pris[i] > model_pris[best]) best = i;
        end
        rsp.id  = model_ids[best];
        rsp.pri = model_pris[best];
        model_ids.delete(best);
        model_pris.delete(best);
      end
      rsp.count = CountW'(model_ids.size());
      expected_responses.push_back(rsp);
    endfunction

    function void check_response(logic [OutDataW-1:0] data);
      response_t got;
      response_t exp;
      got = response_t'(data);
      if (expected_responses.size() == 0) begin
        $error("response 0x%08h arrived with nothing outstanding", data);
        mismatches++;
        return;
      end
      exp = expected_responses.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        mismatches++;
      end
      if (got.id !== exp.id) begin
        $error("removed_id: expected %0d, got %0d", exp.id, got.id);
        mismatches++;
      end
      if (got.pri !== exp.pri) begin
        $error("removed_priority: expected %0d, got %0d", exp.pri, got.pri);
        mismatches++;
      end
      if (got.count !== exp.count) begin
        $error("entry_count: expected %0d, got %0d", exp.count, got.count);
        mismatches++;
      end
      if (got.pad !== exp.pad) begin
        $error("padding: expected %0d, got %0d", exp.pad, got.pad);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_responses.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  queue_scoreboard sb = new();
  int unsigned     src_idle_pct  = 0;
  int unsigned     sink_idle_pct = 0;
  int unsigned     quiet_cycles  = 0;

  max_priority_queue #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver back-pressure, redrawn on every falling edge.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Transaction monitor and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(action_e'(s_axis_tuser), s_axis_tdata[IdW-1:0],
                        s_axis_tdata[IdW+PriW-1:IdW]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_response(m_axis_tdata);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(action_e act, logic [IdW-1:0] pid, logic [PriW-1:0] pri);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = InDataW'($urandom);
      s_axis_tuser  = 1'($urandom);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {pri, pid};
    s_axis_tuser  = act;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random(int unsigned insert_pct);
    action_e         act;
    logic [PriW-1:0] pri;
    act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
    case ($urandom_range(3))
      0: pri = PriW'($urandom_range(3));
      1: pri = $urandom_range(1) ? '1 : '0;
      default: pri = PriW'($urandom);
    endcase
    send_request(act, IdW'($urandom), pri);
  endtask

  initial begin
    logic [PriW-1:0] fill_pri [Capacity];
    int unsigned     insert_pct;
    fill_pri = '{8'hFF, 8'h00, 8'h80, 8'h80, 8'h80, 8'h7F, 8'hFF, 8'h01,
                 8'h80, 8'h00, 8'hFE, 8'h55, 8'hAA, 8'hFF, 8'h00, 8'h80};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_INSERT;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: remove from an empty queue, fill it with extreme values and
    // ties, insert into a full queue, then take a few back out.
    send_request(ACT_REMOVE, '1, '1);
    for (int unsigned i = 0; i < Capacity; i++) begin
      send_request(ACT_INSERT, (i == 1) ? '1 : IdW'(i * 16'h1111), fill_pri[i]);
    end
    send_request(ACT_INSERT, 16'hBEEF, '1);
    for (int unsigned i = 0; i < 4; i++) send_request(ACT_REMOVE, '0, '0);

    // Random: the insert share changes every few dozen transactions so that
    // the queue swings between empty and full.
    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 33; sink_idle_pct = 81; end
        1: begin src_idle_pct = 81; sink_idle_pct = 33; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      insert_pct = 50;
      for (int unsigned n = 0; n < PhaseLen; n++) begin
        if (n % 50 == 0) begin
          case ($urandom_range(2))
            0: insert_pct = 15;
            1: insert_pct = 50;
            default: insert_pct = 85;
          endcase
        end
        send_random(insert_pct);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sb.outstanding() != 0) begin
      $error("%0d responses never arrived", sb.outstanding());
    end
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : max_priority_queue_tb
